// ===== src/spm_pkg.sv =====
// Shared types and codes for the sparse polynomial merge-add block.
package spm_pkg;

   localparam int CoefWidth  = 32;
   localparam int ExpoWidth  = 16;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   typedef logic [1:0] cmd_type;

   localparam cmd_type CMD_APPEND_A = 2'd0;
   localparam cmd_type CMD_APPEND_B = 2'd1;
   localparam cmd_type CMD_MERGE    = 2'd2;

   typedef struct packed {
      logic signed [CoefWidth-1:0] coef;
      logic [ExpoWidth-1:0]        expo;
   } term_type;

   typedef struct packed {
      cmd_type  kind;
      term_type term;
   } op_type;

endpackage

// ===== src/sparse_poly_merge_add.sv =====
// Top level of the sparse polynomial merge-add block.
//
// Usage:
//  - Request channel (req_*): each transfer carries cmd, coef, expo. cmd 0 appends
//    the term to list A, cmd 1 to list B, cmd 2 merges both lists. Code 3 is
//    taken and ignored. Lists are expected in descending exponent order.
//  - Response channel (rsp_*): one transfer per merged term, in descending
//    exponent order; equal exponents give the saturated Q16.16 sum. rsp_last
//    marks the end of a run; two empty lists give one zero term with
//    rsp_empty_res and rsp_last set. rsp_overflow reports dropped appends
//    (append to a full list) since the previous merge.
//  - Flow: requests enter a 4-deep queue at one per cycle while it is not full.
//    An append leaves the queue head while the engine is idle. A merge is taken
//    in the idle state, which loads both list heads, then emits its terms from
//    the run state; the single read port of each list memory feeds one head per
//    cycle. Empty lists give their result straight from the idle state.
//  - Reset (synchronous): empties the queue and both lists, clears the
//    overflow flag and drops any pending response.
//  - rsp_stall holds the response register; merges freeze behind it and the
//    queue keeps taking requests until it fills, then req_stall rises.
module sparse_poly_merge_add #(
   parameter int MAX_TERMS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_cmd,
   input  logic signed [spm_pkg::CoefWidth-1:0] req_coef,
   input  logic [spm_pkg::ExpoWidth-1:0]        req_expo,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [spm_pkg::CoefWidth-1:0] rsp_sum_coef,
   output logic [spm_pkg::ExpoWidth-1:0]        rsp_term_expo,
   output logic                                 rsp_last,
   output logic                                 rsp_empty_res,
   output logic                                 rsp_overflow
);

   logic            q_full, q_push, q_pop, q_valid;
   spm_pkg::op_type push_op, head_op;

   // decode stage: unused codes never reach the queue
   spm_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .req_coef  (req_coef),
      .req_expo  (req_expo),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_op      (push_op)
   );

   // decouples request acceptance from a long merge run
   spm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_op    (push_op),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_op    (head_op)
   );

   // list storage and merge walk; owns the response register
   spm_back #(
      .MAX_TERMS (MAX_TERMS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_op          (head_op),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sum_coef  (rsp_sum_coef),
      .rsp_term_expo (rsp_term_expo),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

// ===== src/spm_front.sv =====
// Front end: accepts request transfers, decodes the command and queues valid operations.
module spm_front (
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_cmd,
   input  logic signed [spm_pkg::CoefWidth-1:0] req_coef,
   input  logic [spm_pkg::ExpoWidth-1:0]     req_expo,
   input  logic                              q_full,
   output logic                              q_push,
   output spm_pkg::op_type                   q_op
);

   logic known_cmd;

   // unused command code is taken and dropped
   assign known_cmd = (req_cmd == spm_pkg::CMD_APPEND_A) ||
                      (req_cmd == spm_pkg::CMD_APPEND_B) ||
                      (req_cmd == spm_pkg::CMD_MERGE);

   assign req_stall      = q_full;
   assign q_push         = req_valid && !q_full && known_cmd;
   assign q_op.kind      = req_cmd;
   assign q_op.term.coef = req_coef;
   assign q_op.term.expo = req_expo;

endmodule

// ===== src/spm_queue.sv =====
// Short FIFO of decoded operations between the front end and the merge engine.
module spm_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  spm_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output logic            head_valid,
   output spm_pkg::op_type head_op
);

   localparam int PW = spm_pkg::QueuePtrW;

   spm_pkg::op_type   slot_ff [spm_pkg::QueueDepth];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       fill_ff, fill_in;

   assign full       = (fill_ff == (PW+1)'(spm_pkg::QueueDepth));
   assign head_valid = (fill_ff != '0);
   assign head_op    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== src/spm_back.sv =====
// Merge engine: term list memories, append handling, merge walk and result register.
module spm_back #(
   parameter int MAX_TERMS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  spm_pkg::op_type                      q_op,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [spm_pkg::CoefWidth-1:0] rsp_sum_coef,
   output logic [spm_pkg::ExpoWidth-1:0]        rsp_term_expo,
   output logic                                 rsp_last,
   output logic                                 rsp_empty_res,
   output logic                                 rsp_overflow
);

   localparam int CW = $clog2(MAX_TERMS + 1);
   localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   spm_pkg::term_type mem_a [MAX_TERMS];
   spm_pkg::term_type mem_b [MAX_TERMS];
   spm_pkg::term_type head_a_ff, head_b_ff;

   logic          state_ff, state_in;
   logic [CW-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CW-1:0] ia_ff, ia_in, ib_ff, ib_in;
   logic          drop_ff, drop_in;
   logic          wr_a, wr_b;
   logic [AW-1:0] rd_a_addr, rd_b_addr;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [spm_pkg::CoefWidth-1:0] coef_ff, coef_in;
   logic [spm_pkg::ExpoWidth-1:0]        expo_ff, expo_in;
   logic                                 last_ff, last_in;
   logic                                 empty_ff, empty_in;
   logic                                 ovf_ff, ovf_in;

   logic                                 can_emit, emit;
   logic                                 a_left, b_left, take_a, take_b;
   logic signed [spm_pkg::CoefWidth:0]   wide_sum;
   logic signed [spm_pkg::CoefWidth-1:0] sat_sum;

   assign can_emit = !rsp_valid_ff || !rsp_stall;

   // heads of both lists, saturating sum of equal exponents
   assign a_left   = (ia_ff != cnt_a_ff);
   assign b_left   = (ib_ff != cnt_b_ff);
   assign take_a   = a_left && (!b_left || (head_a_ff.expo >= head_b_ff.expo));
   assign take_b   = b_left && (!a_left || (head_b_ff.expo >= head_a_ff.expo));
   assign wide_sum = {head_a_ff.coef[spm_pkg::CoefWidth-1], head_a_ff.coef} +
                     {head_b_ff.coef[spm_pkg::CoefWidth-1], head_b_ff.coef};

   always_comb begin
      if (wide_sum[spm_pkg::CoefWidth] != wide_sum[spm_pkg::CoefWidth-1]) begin
         sat_sum = wide_sum[spm_pkg::CoefWidth] ? {1'b1, {(spm_pkg::CoefWidth-1){1'b0}}}
                                                : {1'b0, {(spm_pkg::CoefWidth-1){1'b1}}};
      end else begin
         sat_sum = wide_sum[spm_pkg::CoefWidth-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      ia_in    = ia_ff;
      ib_in    = ib_ff;
      drop_in  = drop_ff;
      wr_a     = 1'b0;
      wr_b     = 1'b0;
      q_pop    = 1'b0;
      emit     = 1'b0;
      coef_in  = coef_ff;
      expo_in  = expo_ff;
      last_in  = 1'b0;
      empty_in = 1'b0;
      ovf_in   = drop_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_op.kind)
                  spm_pkg::CMD_APPEND_A: begin
                     q_pop = 1'b1;
                     if (cnt_a_ff == CW'(MAX_TERMS)) begin
                        drop_in = 1'b1;
                     end else begin
                        wr_a     = 1'b1;
                        cnt_a_in = cnt_a_ff + 1'b1;
                     end
                  end
                  spm_pkg::CMD_APPEND_B: begin
                     q_pop = 1'b1;
                     if (cnt_b_ff == CW'(MAX_TERMS)) begin
                        drop_in = 1'b1;
                     end else begin
                        wr_b     = 1'b1;
                        cnt_b_in = cnt_b_ff + 1'b1;
                     end
                  end
                  spm_pkg::CMD_MERGE: begin
                     if (can_emit) begin
                        q_pop = 1'b1;
                        if (cnt_a_ff == '0 && cnt_b_ff == '0) begin
                           emit     = 1'b1;
                           coef_in  = '0;
                           expo_in  = '0;
                           last_in  = 1'b1;
                           empty_in = 1'b1;
                           drop_in  = 1'b0;
                        end else begin
                           state_in = ST_RUN;
                        end
                     end
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         ST_RUN: begin
            if (can_emit) begin
               emit    = 1'b1;
               expo_in = take_a ? head_a_ff.expo : head_b_ff.expo;
               if (take_a && take_b) begin
                  coef_in = sat_sum;
               end else if (take_a) begin
                  coef_in = head_a_ff.coef;
               end else begin
                  coef_in = head_b_ff.coef;
               end
               ia_in   = ia_ff + CW'(take_a);
               ib_in   = ib_ff + CW'(take_b);
               last_in = (ia_in == cnt_a_ff) && (ib_in == cnt_b_ff);
               if (last_in) begin
                  state_in = ST_IDLE;
                  cnt_a_in = '0;
                  cnt_b_in = '0;
                  ia_in    = '0;
                  ib_in    = '0;
                  drop_in  = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // the head registers track the entries at the next walk indices (entry 0 past the memory end)
   assign rd_a_addr = (ia_in < CW'(MAX_TERMS)) ? ia_in[AW-1:0] : '0;
   assign rd_b_addr = (ib_in < CW'(MAX_TERMS)) ? ib_in[AW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[cnt_a_ff[AW-1:0]] <= q_op.term;
      end
      if (wr_b) begin
         mem_b[cnt_b_ff[AW-1:0]] <= q_op.term;
      end
      head_a_ff <= mem_a[rd_a_addr];
      head_b_ff <= mem_b[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         coef_ff  <= coef_in;
         expo_ff  <= expo_in;
         last_ff  <= last_in;
         empty_ff <= empty_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sum_coef  = coef_ff;
   assign rsp_term_expo = expo_ff;
   assign rsp_last      = last_ff;
   assign rsp_empty_res = empty_ff;
   assign rsp_overflow  = ovf_ff;

endmodule

// ===== src/spm_checker.sv =====
// Port-level checks for the sparse polynomial merge-add block, bound to the top level.
module spm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [spm_pkg::CoefWidth-1:0] rsp_sum_coef,
   input logic [spm_pkg::ExpoWidth-1:0]        rsp_term_expo,
   input logic                                 rsp_last,
   input logic                                 rsp_empty_res
);

   // a stalled response transfer stays offered and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sum_coef) &&
         $stable(rsp_term_expo) && $stable(rsp_last))
      else $error("stalled response changed");

   // the empty result is always the whole run
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last)
      else $error("empty result without last mark");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> (rsp_sum_coef == '0) && (rsp_term_expo == '0))
      else $error("empty result carries a term");

   // reset drops any pending response
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind sparse_poly_merge_add spm_checker u_spm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_sum_coef  (rsp_sum_coef),
   .rsp_term_expo (rsp_term_expo),
   .rsp_last      (rsp_last),
   .rsp_empty_res (rsp_empty_res)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sparse polynomial merge-add block.
module tb;

   localparam int      CoefWidth     = spm_pkg::CoefWidth;
   localparam int      ExpoWidth     = spm_pkg::ExpoWidth;
   localparam int      LIST_DEPTH    = 32;
   localparam int      MAX_GAP       = 17;
   localparam int      HOLD_CYCLES   = 200;   // long receiver hold in the backpressure test
   localparam int      SETTLE_CYCLES = 12;    // queue depth plus pipeline, with margin
   localparam int      DRAIN_LIMIT   = 5000;
   localparam int      TOTAL_ITEMS   = 210;
   localparam spm_pkg::cmd_type CMD_IGNORED = 2'd3;  // unused code, dropped by the block

   // One expected response transfer
   typedef struct {
      logic [CoefWidth-1:0] coef;
      logic [ExpoWidth-1:0] expo;
      logic                 last;
      logic                 is_empty;
      logic                 ovf;
   } merged_term_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_cmd;
   logic [CoefWidth-1:0] req_coef;
   logic [ExpoWidth-1:0] req_expo;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [CoefWidth-1:0] rsp_sum_coef;
   logic [ExpoWidth-1:0] rsp_term_expo;
   logic                 rsp_last;
   logic                 rsp_empty_res;
   logic                 rsp_overflow;

   // Mirror of the block's term lists, counts and sticky drop flag
   spm_pkg::term_type list_a [LIST_DEPTH];
   spm_pkg::term_type list_b [LIST_DEPTH];
   int                len_a = 0;
   int                len_b = 0;
   bit                dropped = 1'b0;
   merged_term_type   pending_terms[$];

   // Side controls: eager means no idle cycles on that side
   bit req_eager    = 1'b0;
   bit rsp_eager    = 1'b0;
   int rsp_hold_req = 0;

   int fail_count    = 0;
   int items_sent    = 0;
   int merges_sent   = 0;
   int terms_checked = 0;
   int drops_seen    = 0;
   int sats_seen     = 0;

   sparse_poly_merge_add #(.MAX_TERMS(LIST_DEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_coef      (req_coef),
      .req_expo      (req_expo),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sum_coef  (rsp_sum_coef),
      .rsp_term_expo (rsp_term_expo),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res),
      .rsp_overflow  (rsp_overflow)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- prediction

   // Q16.16 add, clamped to the 32-bit signed range
   function automatic logic [CoefWidth-1:0] add_sat(input logic [CoefWidth-1:0] x,
                                                    input logic [CoefWidth-1:0] y);
      logic [CoefWidth:0] s;
      s = {x[CoefWidth-1], x} + {y[CoefWidth-1], y};
      if (s[CoefWidth] != s[CoefWidth-1]) begin
         sats_seen++;
         return s[CoefWidth] ? {1'b1, {(CoefWidth-1){1'b0}}} : {1'b0, {(CoefWidth-1){1'b1}}};
      end
      return s[CoefWidth-1:0];
   endfunction

   function automatic void push_term(input logic [CoefWidth-1:0] coef,
                                     input logic [ExpoWidth-1:0] expo, input logic is_empty);
      merged_term_type t;
      t.coef     = coef;
      t.expo     = expo;
      t.last     = 1'b0;
      t.is_empty = is_empty;
      t.ovf      = dropped;
      pending_terms.push_back(t);
   endfunction

   // Walks both list heads; only the current heads are compared, so unordered
   // lists take the same path the hardware does.
   function automatic void merge_lists();
      int              ia;
      int              ib;
      merged_term_type tail;
      ia = 0;
      ib = 0;
      if (len_a == 0 && len_b == 0)
         push_term('0, '0, 1'b1);
      while (ia < len_a && ib < len_b) begin
         if (list_a[ia].expo == list_b[ib].expo) begin
            push_term(add_sat(list_a[ia].coef, list_b[ib].coef), list_a[ia].expo, 1'b0);
            ia++;
            ib++;
         end else if (list_a[ia].expo > list_b[ib].expo) begin
            push_term(list_a[ia].coef, list_a[ia].expo, 1'b0);
            ia++;
         end else begin
            push_term(list_b[ib].coef, list_b[ib].expo, 1'b0);
            ib++;
         end
      end
      for (; ia < len_a; ia++) push_term(list_a[ia].coef, list_a[ia].expo, 1'b0);
      for (; ib < len_b; ib++) push_term(list_b[ib].coef, list_b[ib].expo, 1'b0);
      tail = pending_terms.pop_back();
      tail.last = 1'b1;
      pending_terms.push_back(tail);
      len_a   = 0;
      len_b   = 0;
      dropped = 1'b0;
   endfunction

   function automatic void apply_request(input spm_pkg::cmd_type kind,
                                         input logic [CoefWidth-1:0] coef,
                                         input logic [ExpoWidth-1:0] expo);
      spm_pkg::term_type t;
      t.coef = coef;
      t.expo = expo;
      case (kind)
         spm_pkg::CMD_APPEND_A: begin
            if (len_a >= LIST_DEPTH) begin
               dropped = 1'b1;
               drops_seen++;
            end else begin
               list_a[len_a] = t;
               len_a++;
            end
         end
         spm_pkg::CMD_APPEND_B: begin
            if (len_b >= LIST_DEPTH) begin
               dropped = 1'b1;
               drops_seen++;
            end else begin
               list_b[len_b] = t;
               len_b++;
            end
         end
         spm_pkg::CMD_MERGE: begin
            merges_sent++;
            merge_lists();
         end
         default: ;  // unused code: no state change, no response
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string what, input logic [CoefWidth-1:0] got,
                              input logic [CoefWidth-1:0] want);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
   endtask

   // Every response transfer is matched against the oldest expected term
   always @(posedge clock) begin : term_checker
      merged_term_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_terms.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected term, expected none, actual coef %h expo %h last %b",
                     $time, rsp_sum_coef, rsp_term_expo, rsp_last);
         end else begin
            want = pending_terms.pop_front();
            check_field("sum_coef", rsp_sum_coef, want.coef);
            check_field("term_expo", 32'(rsp_term_expo), 32'(want.expo));
            check_field("last", 32'(rsp_last), 32'(want.last));
            check_field("empty_res", 32'(rsp_empty_res), 32'(want.is_empty));
            check_field("overflow", 32'(rsp_overflow), 32'(want.ovf));
            terms_checked++;
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   // Draws a stall length per transfer; a hold request from the test sequence
   // overrides the draw and is counted here in cycles.
   initial begin : rsp_driver
      int gap;
      rsp_stall = 1'b0;
      forever begin
         if (rsp_hold_req > 0) begin
            gap = rsp_hold_req;
            rsp_hold_req = 0;
         end else begin
            gap = rsp_eager ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall) && rsp_hold_req == 0);
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------- sender

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input spm_pkg::cmd_type kind, input logic [CoefWidth-1:0] coef,
                            input logic [ExpoWidth-1:0] expo);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= kind;
      req_coef  <= coef;
      req_expo  <= expo;
      do @(posedge clock); while (req_stall);
      apply_request(kind, coef, expo);
      if (kind != CMD_IGNORED) items_sent++;
      @(negedge clock);
   endtask

   // Sender goes quiet until every expected term is back, then lets trailing
   // appends work through the queue.
   task automatic drain_results();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (pending_terms.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (pending_terms.size() != 0) begin
         fail_count++;
         $display("%0t: %0d expected terms never arrived, expected 0 left, actual %0d",
                  $time, pending_terms.size(), pending_terms.size());
         pending_terms.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Half full-range values, with a share near both saturation edges and a share of small ones
   function automatic logic [CoefWidth-1:0] rand_coef();
      case ($urandom_range(0, 5))
         0:       return 32'h7FFF_FFFF - $urandom_range(0, 255);
         1:       return 32'h8000_0000 + $urandom_range(0, 255);
         2:       return $urandom_range(0, 511) - 256;
         default: return $urandom;
      endcase
   endfunction

   // One well-formed pair of descending lists built from a shared exponent
   // pool (so equal exponents are common), appended interleaved, then merged.
   // scramble breaks the ordering of one list; noise sprinkles unused codes.
   task automatic send_merge_run(input int pool_n, input bit scramble, input bit noise);
      spm_pkg::term_type terms_a[$];
      spm_pkg::term_type terms_b[$];
      spm_pkg::term_type t;
      spm_pkg::term_type tmp;
      int                e;
      int                i;
      int                j;
      int                pick;
      e = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535);
      for (i = 0; i < pool_n; i++) begin
         t.expo = 16'(e);
         pick = $urandom_range(0, 2);
         if (pick != 1) begin
            t.coef = rand_coef();
            terms_a.push_back(t);
         end
         if (pick != 0) begin
            t.coef = rand_coef();
            terms_b.push_back(t);
         end
         j = $urandom_range(1, 4000);
         e = (e > j) ? e - j : 0;
      end
      if (scramble && terms_a.size() > 1) begin
         i = $urandom_range(0, terms_a.size() - 1);
         j = $urandom_range(0, terms_a.size() - 1);
         tmp = terms_a[i];
         terms_a[i] = terms_a[j];
         terms_a[j] = tmp;
      end
      while (terms_a.size() + terms_b.size() > 0) begin
         if (noise && $urandom_range(0, 7) == 0)
            send_item(CMD_IGNORED, $urandom, 16'($urandom));
         if (terms_b.size() == 0 || (terms_a.size() != 0 && $urandom_range(0, 1) == 1)) begin
            t = terms_a.pop_front();
            send_item(spm_pkg::CMD_APPEND_A, t.coef, t.expo);
         end else begin
            t = terms_b.pop_front();
            send_item(spm_pkg::CMD_APPEND_B, t.coef, t.expo);
         end
      end
      send_item(spm_pkg::CMD_MERGE, $urandom, 16'($urandom));
   endtask

   // ---------------------------------------------------------------- tests

   // Merge of two empty lists, and an unused code that must leave them empty
   task automatic test_empty_merge();
      send_item(spm_pkg::CMD_MERGE, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(CMD_IGNORED, 32'h0001_0000, 16'h0005);
      send_item(spm_pkg::CMD_MERGE, 32'h0, 16'h0);
      drain_results();
   endtask

   // Both saturation edges, a sum of exactly zero, extreme exponents
   task automatic test_saturation_and_zero_sum();
      send_item(spm_pkg::CMD_APPEND_A, 32'h7FFF_FFFF, 16'hFFFF);
      send_item(spm_pkg::CMD_APPEND_B, 32'h0000_0001, 16'hFFFF);
      send_item(spm_pkg::CMD_APPEND_A, 32'h8000_0000, 16'h0100);
      send_item(spm_pkg::CMD_APPEND_B, 32'h8000_0000, 16'h0100);
      send_item(spm_pkg::CMD_APPEND_A, 32'h0001_0000, 16'h0032);
      send_item(spm_pkg::CMD_APPEND_B, 32'hFFFF_0000, 16'h0032);
      send_item(spm_pkg::CMD_APPEND_A, 32'h5555_AAAA, 16'h0000);
      send_item(spm_pkg::CMD_MERGE, 32'h0, 16'h0);
      drain_results();
   endtask

   // Only one list filled: all terms are leftovers
   task automatic test_single_list();
      send_item(spm_pkg::CMD_APPEND_A, 32'hAAAA_5555, 16'h012C);
      send_item(spm_pkg::CMD_APPEND_A, 32'h0000_8000, 16'h0002);
      send_item(spm_pkg::CMD_MERGE, 32'h0, 16'h0);
      send_item(spm_pkg::CMD_APPEND_B, 32'h7FFF_FFFF, 16'hFFFF);
      send_item(spm_pkg::CMD_APPEND_B, 32'h8000_0000, 16'h0000);
      send_item(spm_pkg::CMD_MERGE, 32'h0, 16'h0);
      drain_results();
   endtask

   // List A given in ascending order: heads are compared as they stand
   task automatic test_unordered_lists();
      send_item(spm_pkg::CMD_APPEND_A, 32'h0001_0000, 16'd10);
      send_item(spm_pkg::CMD_APPEND_A, 32'h0002_0000, 16'd20);
      send_item(spm_pkg::CMD_APPEND_B, 32'h0003_0000, 16'd15);
      send_item(spm_pkg::CMD_MERGE, 32'h0, 16'h0);
      drain_results();
   endtask

   // Both lists overfilled: 64 distinct terms out with overflow set, then the
   // flag must be clear on the next run.
   task automatic test_full_lists();
      int i;
      for (i = 0; i < LIST_DEPTH + 2; i++)
         send_item(spm_pkg::CMD_APPEND_A, rand_coef(), 16'(65535 - 2 * i));
      for (i = 0; i < LIST_DEPTH + 1; i++)
         send_item(spm_pkg::CMD_APPEND_B, rand_coef(), 16'(65534 - 2 * i));
      send_item(spm_pkg::CMD_MERGE, $urandom, 16'($urandom));
      send_item(spm_pkg::CMD_APPEND_B, rand_coef(), 16'd7);
      send_item(spm_pkg::CMD_MERGE, $urandom, 16'($urandom));
      drain_results();
   endtask

   // Receiver holds off while the sender keeps offering back-to-back, so the
   // engine freezes, the request queue fills and req_stall rises.
   task automatic test_backpressure();
      req_eager    = 1'b1;
      rsp_hold_req = HOLD_CYCLES;
      while (rsp_hold_req != 0 || !rsp_stall) @(negedge clock);
      send_merge_run(8, 1'b0, 1'b0);
      send_merge_run(6, 1'b0, 1'b1);
      send_merge_run(4, 1'b0, 1'b0);
      req_eager = 1'b0;
      drain_results();
   endtask

   // Random runs, mostly small; some large enough to overflow a list, some
   // with broken ordering or unused codes, and stretches without idling.
   task automatic test_random_runs();
      int target;
      int pool_n;
      target = TOTAL_ITEMS;
      while (items_sent < target) begin
         req_eager = ($urandom_range(0, 5) == 0);
         rsp_eager = ($urandom_range(0, 5) == 0);
         pool_n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 48) : $urandom_range(0, 8);
         send_merge_run(pool_n, $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0)
            drain_results();
      end
      req_eager = 1'b0;
      rsp_eager = 1'b0;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : main_seq
      reset     = 1'b1;
      req_valid = 1'b0;
      req_cmd   = spm_pkg::CMD_APPEND_A;
      req_coef  = '0;
      req_expo  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_merge();
      test_saturation_and_zero_sum();
      test_single_list();
      test_unordered_lists();
      test_full_lists();
      test_backpressure();
      test_random_runs();
      drain_results();

      $display("Run covered %0d requests and %0d merges; %0d merged terms checked.",
               items_sent, merges_sent, terms_checked);
      $display("It saw %0d dropped appends and %0d saturated sums under random idling.",
               drops_seen, sats_seen);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Hard stop: 5 ms is far beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
src/spm_pkg.sv
src/spm_front.sv
src/spm_queue.sv
src/spm_back.sv
src/sparse_poly_merge_add.sv
src/spm_checker.sv
tb/tb.sv
